>>> hdl/twdd_pkg.sv
package twdd_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_KEY   = 2'd2;
  localparam logic [1:0] OP_TIMER = 2'd3;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_DRAW = 2'd1;
  localparam logic [1:0] KIND_FILL = 2'd2;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CON_W = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CON_H = 8'd1;

  localparam int N_CTL = 16;
  localparam logic [3:0] R_WINX     = 4'd0;
  localparam logic [3:0] R_WINY     = 4'd1;
  localparam logic [3:0] R_WINW     = 4'd2;
  localparam logic [3:0] R_WINH     = 4'd3;
  localparam logic [3:0] R_TEXTPTR  = 4'd6;
  localparam logic [3:0] R_COLORPTR = 4'd7;
  localparam logic [3:0] R_FILLOUT  = 4'd9;
  localparam logic [7:0] R_KEY      = 8'd10;
  localparam logic [3:0] R_TIMERLO  = 4'd13;
  localparam logic [3:0] R_TIMERHI  = 4'd14;

  localparam logic [7:0] DEV_PAGE      = 8'hd7;
  localparam logic [7:0] TEXT_PTR_RST  = 8'h04;
  localparam logic [7:0] COLOR_PTR_RST = 8'hd8;
  localparam logic [7:0] GLYPH_BLANK   = 8'h20;
  localparam logic [7:0] COLOUR_RST    = 8'hca;
  localparam logic [7:0] WIN_W_RST     = 8'd40;
  localparam logic [7:0] WIN_H_RST     = 8'd25;
  localparam logic [7:0] CON_W_RST     = 8'd80;
  localparam logic [7:0] CON_H_RST     = 8'd25;
  localparam int         PAL_ENTRIES   = 48;

  localparam logic [7:0] BASE_COLOURS [PAL_ENTRIES] = '{
    8'hFF, 8'hFF, 8'hFF, 8'h68, 8'h37, 8'h2B, 8'h58, 8'h8D, 8'h43, 8'h35, 8'h28, 8'h79,
    8'h6F, 8'h4F, 8'h25, 8'h00, 8'h00, 8'h00, 8'h43, 8'h39, 8'h00, 8'h9A, 8'h67, 8'h59,
    8'h44, 8'h44, 8'h44, 8'h6C, 8'h6C, 8'h6C, 8'h9A, 8'hD2, 8'h84, 8'h6C, 8'h5E, 8'hB5,
    8'h95, 8'h95, 8'h95, 8'h6F, 8'h3D, 8'h86, 8'hB8, 8'hC7, 8'h6F, 8'h70, 8'hA4, 8'hB2
  };

  typedef enum logic [2:0] {
    CLS_KEY,
    CLS_TIMER,
    CLS_RD_NONE,
    CLS_RD_PAL,
    CLS_RD_KEY,
    CLS_RD_REG,
    CLS_WRITE
  } cls_e;

  typedef struct packed {
    cls_e        cls;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  key;
    logic [15:0] frame;
  } item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RDWAIT,
    S_DIV,
    S_PAL_A,
    S_PAL_D,
    S_RESULT
  } state_e;

  function automatic logic [7:0] pal_reset(logic [6:0] i);
    logic [7:0] v;
    if (i < 7'd48) begin
      v = BASE_COLOURS[i[5:0]];
    end else if (i < 7'd96) begin
      v = BASE_COLOURS[6'(i - 7'd48)];
    end else begin
      v = 8'h00;
    end
    return v;
  endfunction

  function automatic logic [7:0] centre(logic [7:0] con, logic [7:0] win);
    logic [7:0] d;
    d = con - win;
    return (con >= win) ? {1'b0, d[7:1]} : 8'h00;
  endfunction

endpackage

>>> hdl/text_window_display_device_unit.sv
// Memory-mapped text display. After reset the block steps through all CELL_CAPACITY
// addresses loading the text, colour, palette and register stores with their start values
// and takes no item meanwhile; configuration writes are taken at any time. A two-beat input
// queue feeds a sequencer that handles one item at a time: key arrivals, timer updates and
// reads or writes with no result go back to idle after decode, bus reads pass a read-wait
// state, a fill makes six palette reads for the two colours and a draw runs the 16-step
// divider for the cell position before those reads, each an address and a data state. The
// result register frees the sequencer as soon as a result is handed over.
module text_window_display_device_unit
  import twdd_pkg::*;
#(
  parameter int CELL_CAPACITY = 2048,
  parameter int KEY_DEPTH     = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [15:0]          address_i,
  input  logic [7:0]           write_data_i,
  input  logic [7:0]           key_code_i,
  input  logic [15:0]          frame_count_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           read_data_o,
  output logic [8:0]           column_o,
  output logic [8:0]           row_o,
  output logic [7:0]           glyph_o,
  output logic [23:0]          fg_rgb_o,
  output logic [23:0]          bg_rgb_o,
  output logic [7:0]           win_left_o,
  output logic [7:0]           win_top_o,
  output logic [7:0]           win_cols_o,
  output logic [7:0]           win_rows_o
);

  item_t item;
  logic  item_valid, pop, busy;

  assign cfg_ready_o = 1'b1;

  twdd_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .op_i,
    .address_i,
    .write_data_i,
    .key_code_i,
    .frame_count_i,
    .busy_i       (busy),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  twdd_back #(
    .CELL_CAPACITY (CELL_CAPACITY),
    .KEY_DEPTH     (KEY_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .busy_o       (busy),
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .read_data_o,
    .column_o,
    .row_o,
    .glyph_o,
    .fg_rgb_o,
    .bg_rgb_o,
    .win_left_o,
    .win_top_o,
    .win_cols_o,
    .win_rows_o
  );

endmodule

>>> hdl/twdd_front.sv
module twdd_front
  import twdd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  key_code_i,
  input  logic [15:0] frame_count_i,
  input  logic        busy_i,
  input  logic        pop_i,
  output logic        item_valid_o,
  output item_t       item_o
);

  item_t       fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  item_t       item_in;

  always_comb begin
    item_in.address = address_i;
    item_in.data    = write_data_i;
    item_in.key     = key_code_i;
    item_in.frame   = frame_count_i;
    unique case (op_i)
      OP_KEY:   item_in.cls = CLS_KEY;
      OP_TIMER: item_in.cls = CLS_TIMER;
      OP_WRITE: item_in.cls = CLS_WRITE;
      default: begin
        if (address_i[15:8] != DEV_PAGE) begin
          item_in.cls = CLS_RD_NONE;
        end else if (address_i[7]) begin
          item_in.cls = CLS_RD_PAL;
        end else if (address_i[7:0] == R_KEY) begin
          item_in.cls = CLS_RD_KEY;
        end else begin
          item_in.cls = CLS_RD_REG;
        end
      end
    endcase
  end

  assign in_stall_o   = (cnt_q == 2'd2) || busy_i;
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = pop_i && item_valid_o;
  assign item_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> hdl/twdd_back.sv
module twdd_back
  import twdd_pkg::*;
#(
  parameter int CELL_CAPACITY = 2048,
  parameter int KEY_DEPTH     = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  item_t                item_i,
  output logic                 pop_o,
  output logic                 busy_o,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           read_data_o,
  output logic [8:0]           column_o,
  output logic [8:0]           row_o,
  output logic [7:0]           glyph_o,
  output logic [23:0]          fg_rgb_o,
  output logic [23:0]          bg_rgb_o,
  output logic [7:0]           win_left_o,
  output logic [7:0]           win_top_o,
  output logic [7:0]           win_cols_o,
  output logic [7:0]           win_rows_o
);

  localparam int CW = $clog2(CELL_CAPACITY);
  localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  state_e          state_q, state_d;
  item_t           item_q;
  logic [7:0]      ctl_q [N_CTL];
  logic [7:0]      con_w_q, con_h_q;
  logic [15:0]     area_q;
  logic [CW-1:0]   clr_q;

  logic [7:0]      text_mem [CELL_CAPACITY];
  logic [7:0]      colour_mem [CELL_CAPACITY];
  logic [7:0]      pal_mem [128];
  logic [7:0]      reg_mem [128];
  logic [7:0]      key_mem [KEY_DEPTH];
  logic [7:0]      text_rd_q, colour_rd_q, pal_rd_q, reg_rd_q, key_rd_q;

  logic [KW-1:0]   head_q, tail_q;
  logic [KW:0]     kcnt_q;
  logic            key_had_q;

  logic [15:0]     off_q, quo_q;
  logic [7:0]      rem_q;
  logic [3:0]      step_q;
  logic [2:0]      k_q;
  logic [7:0]      col_q, glyph_q, rdata_q;
  logic [47:0]     rgb_q;
  logic [1:0]      kind_q;

  logic            clearing, decode, clr_last, clr_low;
  logic [16:0]     pages_sum;
  logic [8:0]      pages;
  logic [15:0]     off_c, off_txt, off_sel;
  logic            col_claim, txt_claim, in_win, is_write, dev_hit;
  logic            wr_col, wr_txt, wr_pal, wr_reg, wr_ctl, is_fill, do_draw;
  logic            key_push, key_pop, timer_we, cfg_we;
  logic [CW-1:0]   st_addr;
  logic [6:0]      pal_waddr, pal_raddr, reg_waddr;
  logic [6:0]      fi, bi, pal_a;
  logic [4:0]      be;
  logic [8:0]      div_trial;
  logic            div_ge;
  logic [7:0]      rd_sel;
  logic            out_free;
  logic [7:0]      cw_new, ch_new;

  assign clearing = (state_q == S_CLEAR);
  assign decode   = (state_q == S_DECODE);
  assign busy_o   = clearing;
  assign clr_last = (clr_q == CW'(CELL_CAPACITY - 1));
  assign clr_low  = (clr_q < CW'(128));
  assign out_free = !out_valid_o || !out_stall_i;
  assign pop_o    = (state_q == S_IDLE);

  assign pages_sum = {1'b0, area_q} + 17'd255;
  assign pages     = pages_sum[16:8];
  assign off_c     = item_q.address - {ctl_q[R_COLORPTR], 8'h00};
  assign off_txt   = item_q.address - {ctl_q[R_TEXTPTR], 8'h00};
  assign col_claim = ({1'b0, off_c[15:8]} < pages);
  assign txt_claim = ({1'b0, off_txt[15:8]} < pages);
  assign off_sel   = col_claim ? off_c : off_txt;
  assign in_win    = (off_sel < area_q) && ({1'b0, off_sel} < 17'(CELL_CAPACITY));
  assign is_write  = decode && (item_q.cls == CLS_WRITE);
  assign dev_hit   = is_write && !col_claim && !txt_claim && (item_q.address[15:8] == DEV_PAGE);
  assign wr_col    = is_write && col_claim && in_win;
  assign wr_txt    = is_write && !col_claim && txt_claim && in_win;
  assign do_draw   = wr_col || wr_txt;
  assign wr_pal    = dev_hit && item_q.address[7];
  assign wr_reg    = dev_hit && !item_q.address[7] && (item_q.address[6:4] != 3'd0);
  assign wr_ctl    = dev_hit && !item_q.address[7] && (item_q.address[6:4] == 3'd0);
  assign is_fill   = wr_ctl && (item_q.address[3:0] == R_FILLOUT);
  assign key_push  = decode && (item_q.cls == CLS_KEY) && (kcnt_q < (KW+1)'(KEY_DEPTH));
  assign key_pop   = decode && (item_q.cls == CLS_RD_KEY) && (kcnt_q != '0);
  assign timer_we  = decode && (item_q.cls == CLS_TIMER);
  assign cfg_we    = cfg_valid_i;

  assign st_addr   = clearing ? clr_q : off_sel[CW-1:0];
  assign pal_waddr = clearing ? clr_q[6:0] : item_q.address[6:0];
  assign reg_waddr = clearing ? clr_q[6:0] : item_q.address[6:0];

  assign fi    = 7'({col_q[3:0], 1'b0}) + 7'(col_q[3:0]);
  assign be    = {1'b1, col_q[7:4]};
  assign bi    = 7'({be, 1'b0}) + 7'(be);
  assign pal_a = (k_q < 3'd3) ? (fi + 7'(k_q)) : (bi + 7'(k_q - 3'd3));
  assign pal_raddr = (state_q == S_PAL_A) ? pal_a : item_q.address[6:0];

  assign div_trial = {rem_q, quo_q[15]};
  assign div_ge    = (div_trial >= {1'b0, ctl_q[R_WINW]});

  always_comb begin
    unique case (item_q.cls)
      CLS_RD_PAL: rd_sel = pal_rd_q;
      CLS_RD_KEY: rd_sel = key_had_q ? key_rd_q : 8'h00;
      default: begin
        rd_sel = (item_q.address[6:4] == 3'd0) ? ctl_q[item_q.address[3:0]] : reg_rd_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (item_q.cls)
          CLS_RD_PAL, CLS_RD_KEY, CLS_RD_REG: state_d = S_RDWAIT;
          CLS_WRITE: begin
            if (do_draw) begin
              state_d = S_DIV;
            end else if (is_fill) begin
              state_d = S_PAL_A;
            end else begin
              state_d = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RDWAIT: state_d = S_RESULT;
      S_DIV: begin
        if (step_q == 4'd15) begin
          state_d = S_PAL_A;
        end
      end
      S_PAL_A: state_d = S_PAL_D;
      S_PAL_D: state_d = (k_q == 3'd5) ? S_RESULT : S_PAL_A;
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) begin
        clr_q <= clr_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing || wr_txt) begin
      text_mem[st_addr] <= clearing ? GLYPH_BLANK : item_q.data;
    end
    text_rd_q <= text_mem[off_q[CW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (clearing || wr_col) begin
      colour_mem[st_addr] <= clearing ? COLOUR_RST : item_q.data;
    end
    colour_rd_q <= colour_mem[off_q[CW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if ((clearing && clr_low) || wr_pal) begin
      pal_mem[pal_waddr] <= clearing ? pal_reset(clr_q[6:0]) : item_q.data;
    end
    pal_rd_q <= pal_mem[pal_raddr];
  end

  always_ff @(posedge clk_i) begin
    if ((clearing && clr_low) || wr_reg) begin
      reg_mem[reg_waddr] <= clearing ? 8'h00 : item_q.data;
    end
    reg_rd_q <= reg_mem[item_q.address[6:0]];
  end

  always_ff @(posedge clk_i) begin
    if (key_push) begin
      key_mem[tail_q] <= item_q.key;
    end
    key_rd_q <= key_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      kcnt_q <= '0;
    end else begin
      if (key_push) begin
        tail_q <= (tail_q == KW'(KEY_DEPTH - 1)) ? '0 : tail_q + KW'(1);
      end
      if (key_pop) begin
        head_q <= (head_q == KW'(KEY_DEPTH - 1)) ? '0 : head_q + KW'(1);
      end
      kcnt_q <= kcnt_q + (KW+1)'(key_push) - (KW+1)'(key_pop);
    end
  end

  assign cw_new = (cfg_index_i == CFG_CON_W) ? cfg_data_i : con_w_q;
  assign ch_new = (cfg_index_i == CFG_CON_H) ? cfg_data_i : con_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_CTL; i++) begin
        ctl_q[i] <= 8'h00;
      end
      ctl_q[R_WINX]     <= centre(CON_W_RST, WIN_W_RST);
      ctl_q[R_WINY]     <= centre(CON_H_RST, WIN_H_RST);
      ctl_q[R_WINW]     <= WIN_W_RST;
      ctl_q[R_WINH]     <= WIN_H_RST;
      ctl_q[R_TEXTPTR]  <= TEXT_PTR_RST;
      ctl_q[R_COLORPTR] <= COLOR_PTR_RST;
      con_w_q           <= CON_W_RST;
      con_h_q           <= CON_H_RST;
    end else begin
      if (cfg_we && ((cfg_index_i == CFG_CON_W) || (cfg_index_i == CFG_CON_H))) begin
        con_w_q       <= cw_new;
        con_h_q       <= ch_new;
        ctl_q[R_WINX] <= centre(cw_new, ctl_q[R_WINW]);
        ctl_q[R_WINY] <= centre(ch_new, ctl_q[R_WINH]);
      end else if (timer_we) begin
        ctl_q[R_TIMERLO] <= item_q.frame[7:0];
        ctl_q[R_TIMERHI] <= item_q.frame[15:8];
      end else if (wr_ctl) begin
        ctl_q[item_q.address[3:0]] <= item_q.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    area_q <= ctl_q[R_WINW] * ctl_q[R_WINH];
    if (state_q == S_IDLE) begin
      item_q <= item_i;
    end
    if (decode) begin
      off_q     <= off_sel;
      quo_q     <= off_sel;
      rem_q     <= 8'h00;
      step_q    <= 4'd0;
      k_q       <= 3'd0;
      col_q     <= item_q.data;
      key_had_q <= (kcnt_q != '0);
      kind_q    <= do_draw ? KIND_DRAW : (is_fill ? KIND_FILL : KIND_READ);
    end
    if (state_q == S_DIV) begin
      quo_q  <= {quo_q[14:0], div_ge};
      rem_q  <= div_ge ? 8'(div_trial - {1'b0, ctl_q[R_WINW]}) : div_trial[7:0];
      step_q <= step_q + 4'd1;
      if (step_q == 4'd15) begin
        col_q   <= colour_rd_q;
        glyph_q <= text_rd_q;
      end
    end
    if (state_q == S_PAL_D) begin
      rgb_q <= {rgb_q[39:0], pal_rd_q};
      k_q   <= k_q + 3'd1;
    end
    if (state_q == S_RDWAIT) begin
      rdata_q <= rd_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == S_RESULT && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESULT && out_free) begin
      kind_o      <= kind_q;
      read_data_o <= 8'h00;
      column_o    <= 9'd0;
      row_o       <= 9'd0;
      glyph_o     <= 8'h00;
      fg_rgb_o    <= 24'd0;
      bg_rgb_o    <= 24'd0;
      win_left_o  <= 8'h00;
      win_top_o   <= 8'h00;
      win_cols_o  <= 8'h00;
      win_rows_o  <= 8'h00;
      unique case (kind_q)
        KIND_DRAW: begin
          column_o <= {1'b0, rem_q} + {1'b0, ctl_q[R_WINX]};
          row_o    <= quo_q[8:0] + {1'b0, ctl_q[R_WINY]};
          glyph_o  <= glyph_q;
          fg_rgb_o <= rgb_q[47:24];
          bg_rgb_o <= rgb_q[23:0];
        end
        KIND_FILL: begin
          glyph_o    <= GLYPH_BLANK;
          fg_rgb_o   <= rgb_q[47:24];
          bg_rgb_o   <= rgb_q[23:0];
          win_left_o <= ctl_q[R_WINX];
          win_top_o  <= ctl_q[R_WINY];
          win_cols_o <= ctl_q[R_WINW];
          win_rows_o <= ctl_q[R_WINH];
        end
        default: begin
          read_data_o <= rdata_q;
        end
      endcase
    end
  end

endmodule
